[src/tun_pkg.sv]
package tun_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 15;
	localparam int FIELD_W         = 16;
	localparam int OUT_W           = 16;

	// Request to output latency in cycles for the default configuration.
	localparam int TUN_LAT = (2 * FRAC_BITS_DEF + 3) + (FRAC_BITS_DEF + 2) + 6;

	typedef struct packed {
		logic signed [FIELD_W-1:0] p1_x;
		logic signed [FIELD_W-1:0] p1_y;
		logic signed [FIELD_W-1:0] p1_z;
		logic signed [FIELD_W-1:0] p2_x;
		logic signed [FIELD_W-1:0] p2_y;
		logic signed [FIELD_W-1:0] p2_z;
		logic signed [FIELD_W-1:0] p3_x;
		logic signed [FIELD_W-1:0] p3_y;
		logic signed [FIELD_W-1:0] p3_z;
	} vtx_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] nx;
		logic signed [OUT_W-1:0] ny;
		logic signed [OUT_W-1:0] nz;
		logic                    degenerate;
	} nrm_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
	} meta_t;

endpackage

[src/tun_front.sv]
module tun_front import tun_pkg::*; #(
	parameter int CW  = COORD_WIDTH_DEF,
	parameter int SQW = 2 * (2 * (CW + 1) + 1),
	parameter int SW  = SQW + 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  vtx_t           vtx,
	output logic           valid,
	output meta_t          meta,
	output logic [SQW-1:0] sq0,
	output logic [SQW-1:0] sq1,
	output logic [SQW-1:0] sq2,
	output logic [SW-1:0]  sum
);

	localparam int EW  = CW + 1;
	localparam int PW  = 2 * EW;
	localparam int CRW = PW + 1;
	localparam int LW  = (CRW + 1) / 2;
	localparam int HW  = CRW - LW;

	logic signed [CW-1:0] c1x, c1y, c1z, c2x, c2y, c2z, c3x, c3y, c3z;
	logic signed [EW-1:0] ax, ay, az, bx, by, bz;
	logic signed [PW-1:0] prod_s1 [6];
	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [CRW-1:0] cr [3];
	logic [CRW-1:0]       mag_s2 [3];
	meta_t                meta_s2, meta_s3, meta_s4, meta_s5;
	logic [2*HW-1:0]      hh_s3 [3];
	logic [HW+LW-1:0]     hl_s3 [3];
	logic [2*LW-1:0]      ll_s3 [3];
	logic [SQW-1:0]       sq_s4 [3];
	logic [SQW-1:0]       sq_s5 [3];
	logic [SW-1:0]        sum_s5;

	assign c1x = CW'(vtx.p1_x);
	assign c1y = CW'(vtx.p1_y);
	assign c1z = CW'(vtx.p1_z);
	assign c2x = CW'(vtx.p2_x);
	assign c2y = CW'(vtx.p2_y);
	assign c2z = CW'(vtx.p2_z);
	assign c3x = CW'(vtx.p3_x);
	assign c3y = CW'(vtx.p3_y);
	assign c3z = CW'(vtx.p3_z);

	assign ax = $signed({c1x[CW-1], c1x}) - $signed({c2x[CW-1], c2x});
	assign ay = $signed({c1y[CW-1], c1y}) - $signed({c2y[CW-1], c2y});
	assign az = $signed({c1z[CW-1], c1z}) - $signed({c2z[CW-1], c2z});
	assign bx = $signed({c2x[CW-1], c2x}) - $signed({c3x[CW-1], c3x});
	assign by = $signed({c2y[CW-1], c2y}) - $signed({c3y[CW-1], c3y});
	assign bz = $signed({c2z[CW-1], c2z}) - $signed({c3z[CW-1], c3z});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr[i] = $signed({prod_s1[2*i][PW-1], prod_s1[2*i]})
				- $signed({prod_s1[2*i+1][PW-1], prod_s1[2*i+1]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1[0] <= ay * bz;
		prod_s1[1] <= az * by;
		prod_s1[2] <= az * bx;
		prod_s1[3] <= ax * bz;
		prod_s1[4] <= ax * by;
		prod_s1[5] <= ay * bx;

		for (int i = 0; i < 3; i++) begin
			meta_s2.neg[i] <= cr[i][CRW-1];
			mag_s2[i]      <= cr[i][CRW-1] ? CRW'(-cr[i]) : CRW'(cr[i]);
		end
		meta_s2.degen <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);

		for (int i = 0; i < 3; i++) begin
			hh_s3[i] <= mag_s2[i][CRW-1:LW] * mag_s2[i][CRW-1:LW];
			hl_s3[i] <= mag_s2[i][CRW-1:LW] * mag_s2[i][LW-1:0];
			ll_s3[i] <= mag_s2[i][LW-1:0] * mag_s2[i][LW-1:0];
		end
		meta_s3 <= meta_s2;

		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= (SQW'(hh_s3[i]) << (2 * LW)) + (SQW'(hl_s3[i]) << (LW + 1))
				+ SQW'(ll_s3[i]);
		end
		meta_s4 <= meta_s3;

		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= sq_s4[i];
		end
		sum_s5  <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
		meta_s5 <= meta_s4;
	end

	assign valid = vld_s5;
	assign meta  = meta_s5;
	assign sq0   = sq_s5[0];
	assign sq1   = sq_s5[1];
	assign sq2   = sq_s5[2];
	assign sum   = sum_s5;

endmodule

[src/tun_div.sv]
module tun_div import tun_pkg::*; #(
	parameter int SW = 72,
	parameter int QW = 2 * FRAC_BITS_DEF + 3
) (
	input  logic          clk,
	input  logic [SW-1:0] num,
	input  logic [SW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [SW:0]   rem_s [QW];
	logic [SW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [SW:0]   rin;
		logic [SW-1:0] din;
		logic [QW-1:0] qin;
		logic [SW:0]   rd;
		logic          ge;

		if (k == 0) begin : g_first
			assign rin = {1'b0, num};
			assign din = den;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign din = den_s[k-1];
			assign qin = quo_s[k-1];
		end

		assign ge = rin >= {1'b0, din};
		assign rd = ge ? rin - {1'b0, din} : rin;

		always_ff @(posedge clk) begin
			rem_s[k] <= {rd[SW-1:0], 1'b0};
			den_s[k] <= din;
			quo_s[k] <= {qin[QW-2:0], ge};
		end
	end

	assign quo = quo_s[QW-1];

endmodule

[src/tun_sqrt.sv]
module tun_sqrt import tun_pkg::*; #(
	parameter int QW = 2 * FRAC_BITS_DEF + 3,
	parameter int RW = (QW + 1) / 2
) (
	input  logic          clk,
	input  logic [QW-1:0] rad,
	output logic [RW-1:0] root
);

	logic [2*RW-1:0] rad_s  [RW];
	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [2*RW-1:0] radin;
		logic [RW+1:0]   remin;
		logic [RW-1:0]   rootin;
		logic [RW+1:0]   cur;
		logic [RW+1:0]   trial;
		logic            ge;

		if (i == 0) begin : g_first
			assign radin  = (2 * RW)'(rad);
			assign remin  = '0;
			assign rootin = '0;
		end else begin : g_next
			assign radin  = rad_s[i-1];
			assign remin  = rem_s[i-1];
			assign rootin = root_s[i-1];
		end

		assign cur   = {remin[RW-1:0], radin[2*(RW-1-i)+1 -: 2]};
		assign trial = {rootin, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk) begin
			rad_s[i]  <= radin;
			rem_s[i]  <= ge ? cur - trial : cur;
			root_s[i] <= {rootin[RW-2:0], ge};
		end
	end

	assign root = root_s[RW-1];

endmodule

[src/triangle_unit_normal_core.sv]
// Channel   Handshake               Payload  Width
// request   start, busy             vtx      9 x 16 signed
// result    done (one-cycle strobe) nrm      3 x 16 signed + 1
//
// One request is taken every cycle; busy is never raised.
// The latency is set by the front end, the bit-per-stage divider, the bit-pair-per-stage
// square root and the output register.
// The receiver cannot stall, so the pipeline always advances.
// Reset clears only the valid bits; no data is held across requests.
module triangle_unit_normal_core import tun_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  vtx_t vtx,
	output logic done,
	output nrm_t nrm
);

	localparam int CRW = 2 * (COORD_WIDTH + 1) + 1;
	localparam int SQW = 2 * CRW;
	localparam int SW  = SQW + 2;
	localparam int QW  = 2 * FRAC_BITS + 3;
	localparam int RW  = (QW + 1) / 2;
	localparam int DL  = QW + RW;

	logic           f_valid;
	meta_t          f_meta;
	logic [SQW-1:0] sq [3];
	logic [SW-1:0]  sum;
	logic [QW-1:0]  quo [3];
	logic [RW-1:0]  root [3];
	logic           vld_q [DL];
	meta_t          meta_q [DL];
	logic [OUT_W-1:0] comp [3];
	logic           done_q;
	nrm_t           nrm_q;

	assign busy = 1'b0;

	tun_front #(
		.CW  (COORD_WIDTH),
		.SQW (SQW),
		.SW  (SW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.vtx    (vtx),
		.valid  (f_valid),
		.meta   (f_meta),
		.sq0    (sq[0]),
		.sq1    (sq[1]),
		.sq2    (sq[2]),
		.sum    (sum)
	);

	for (genvar l = 0; l < 3; l++) begin : g_lane
		tun_div #(
			.SW (SW),
			.QW (QW)
		) u_div (
			.clk (clk),
			.num (SW'(sq[l])),
			.den (sum),
			.quo (quo[l])
		);

		tun_sqrt #(
			.QW (QW),
			.RW (RW)
		) u_sqrt (
			.clk  (clk),
			.rad  (quo[l]),
			.root (root[l])
		);

		logic [RW-1:0]      q;
		logic [RW-1:0]      qs;
		logic signed [RW:0] sv;

		assign q  = RW'(root[l] + RW'(1)) >> 1;
		assign qs = (!meta_q[DL-1].neg[l] && q >= (RW'(1) << FRAC_BITS))
			? (RW'(1) << FRAC_BITS) - RW'(1) : q;
		assign sv = meta_q[DL-1].neg[l] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
		assign comp[l] = meta_q[DL-1].degen ? '0 : OUT_W'(sv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL; i++) begin
				vld_q[i] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			vld_q[0] <= f_valid;
			for (int i = 1; i < DL; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
			done_q <= vld_q[DL-1];
		end
	end

	always_ff @(posedge clk) begin
		meta_q[0] <= f_meta;
		for (int i = 1; i < DL; i++) begin
			meta_q[i] <= meta_q[i-1];
		end
		nrm_q.nx         <= comp[0];
		nrm_q.ny         <= comp[1];
		nrm_q.nz         <= comp[2];
		nrm_q.degenerate <= meta_q[DL-1].degen;
	end

	assign done = done_q;
	assign nrm  = nrm_q;

endmodule

[src/tun_chk.sv]
module tun_chk import tun_pkg::*; #(
	parameter int LAT = TUN_LAT
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input vtx_t vtx,
	input logic done,
	input nrm_t nrm
);

	// A degenerate triangle reports a zero normal.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && nrm.degenerate |-> nrm.nx == '0 && nrm.ny == '0 && nrm.nz == '0)
		else $error("degenerate result with nonzero normal");

	// Every accepted request gives exactly one result after the fixed latency.
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after request");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result without request");

	// A triangle whose first two vertices coincide has no area.
	a_same_vtx: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && vtx.p1_x == vtx.p2_x && vtx.p1_y == vtx.p2_y
		&& vtx.p1_z == vtx.p2_z |-> ##LAT nrm.degenerate)
		else $error("coincident vertices not flagged degenerate");

endmodule

bind triangle_unit_normal_core tun_chk u_tun_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.vtx    (vtx),
	.done   (done),
	.nrm    (nrm)
);
